/* sv/assert_macros.svh */
// Assertion helpers; the enclosing module must provide clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define HFSL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define HFSL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/hfsl_pkg.sv */
package hfsl_pkg;

  localparam int HEAD_W = 16;
  localparam int VEL_W  = 16;
  localparam int CFG_W  = 15;
  localparam int SQ_W   = 31;
  localparam int THR_W  = 2 * CFG_W;
  // CORDIC datapath: |v| * 2^14 * sqrt(2) * gain stays below 2^31
  localparam int XY_W   = 32;
  localparam int PRESCALE = 14;

  localparam int DEF_ANGLE_BITS   = 16;
  localparam int DEF_CORDIC_STEPS = 16;
  localparam int DEF_QUEUE_DEPTH  = 4;

  localparam logic [CFG_W-1:0] DEF_FOLLOW_SPEED = 15'd300;
  localparam logic [CFG_W-1:0] DEF_STEP_LIMIT   = 15'd218;
  localparam logic [THR_W-1:0] DEF_SPEED_SQ     = 30'd90000;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_FOLLOW_SPEED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_LIMIT   = 2'd1;

  typedef enum logic [1:0] {
    KIND_HOLD   = 2'd0,
    KIND_FOLLOW = 2'd1,
    KIND_SEED   = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e                   kind;
    logic [HEAD_W-1:0]       heading;
    logic signed [VEL_W-1:0] north;
    logic signed [VEL_W-1:0] east;
  } item_t;

  typedef struct packed {
    logic [THR_W-1:0] speed_sq;
    logic [CFG_W-1:0] step_limit;
  } cfg_t;

  // atan(2^-i) as a fraction of a turn, scaled by 2^32
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

/* sv/heading_follow_slew_limiter.sv */
// Channel   | Handshake                  | Payload
// ----------+----------------------------+------------------------------------------
// input     | push / full                | seed, seed_heading, velocity_valid/north/east
// result    | pop / empty                | commanded_heading, following
// config    | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// Input accepted every cycle while the front queue has room; the front registers the
// speed squares and classifies the item from them.
// Back end: a following item passes through pop, the iterations of the shared shift-add
// CORDIC, rounding and slew apply; hold and seed items go from pop straight to apply.
// With its single CORDIC unit the back end takes a new item only after the last is applied.
// Reset clears the heading to zero and the registers to 300 and 218; no clearing pass.
// A result held on the ports stalls the back end; the queue keeps the front accepting.
module heading_follow_slew_limiter #(
  parameter int ANGLE_BITS   = hfsl_pkg::DEF_ANGLE_BITS,
  parameter int CORDIC_STEPS = hfsl_pkg::DEF_CORDIC_STEPS,
  parameter int QUEUE_DEPTH  = hfsl_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic                                seed_i,
  input  logic signed [hfsl_pkg::HEAD_W-1:0]  seed_heading_i,
  input  logic                                velocity_valid_i,
  input  logic signed [hfsl_pkg::VEL_W-1:0]   velocity_north_i,
  input  logic signed [hfsl_pkg::VEL_W-1:0]   velocity_east_i,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [hfsl_pkg::HEAD_W-1:0]  commanded_heading_o,
  output logic                                following_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [hfsl_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [hfsl_pkg::CFG_W-1:0]          cfg_data_i
);

  localparam int ITEM_W = $bits(hfsl_pkg::item_t);

  logic [hfsl_pkg::CFG_W-1:0] follow_speed_q, step_limit_q;
  logic [hfsl_pkg::THR_W-1:0] speed_sq_q;
  hfsl_pkg::cfg_t             cfg;
  hfsl_pkg::item_t            front_item, back_item;
  logic [ITEM_W-1:0]          q_rd_data;
  logic                       q_push, q_full, q_pop, q_empty;

  assign cfg_ready_o    = 1'b1;
  assign cfg.speed_sq   = speed_sq_q;
  assign cfg.step_limit = step_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      follow_speed_q <= hfsl_pkg::DEF_FOLLOW_SPEED;
      step_limit_q   <= hfsl_pkg::DEF_STEP_LIMIT;
      speed_sq_q     <= hfsl_pkg::DEF_SPEED_SQ;
    end else begin
      speed_sq_q <= hfsl_pkg::THR_W'(follow_speed_q) * hfsl_pkg::THR_W'(follow_speed_q);
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          hfsl_pkg::REG_FOLLOW_SPEED: follow_speed_q <= cfg_data_i;
          hfsl_pkg::REG_STEP_LIMIT:   step_limit_q   <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  hfsl_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .seed_i           (seed_i),
    .seed_heading_i   (seed_heading_i),
    .velocity_valid_i (velocity_valid_i),
    .velocity_north_i (velocity_north_i),
    .velocity_east_i  (velocity_east_i),
    .cfg_i            (cfg),
    .q_push_o         (q_push),
    .q_full_i         (q_full),
    .q_item_o         (front_item)
  );

  hfsl_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .full_o  (q_full),
    .data_i  (front_item),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_rd_data)
  );

  assign back_item = hfsl_pkg::item_t'(q_rd_data);

  hfsl_back #(
    .ANGLE_BITS   (ANGLE_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_i               (cfg),
    .q_empty_i           (q_empty),
    .q_pop_o             (q_pop),
    .q_item_i            (back_item),
    .empty               (empty),
    .pop                 (pop),
    .commanded_heading_o (commanded_heading_o),
    .following_o         (following_o)
  );

endmodule

/* sv/hfsl_front.sv */
module hfsl_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  logic                            seed_i,
  input  logic [hfsl_pkg::HEAD_W-1:0]     seed_heading_i,
  input  logic                            velocity_valid_i,
  input  logic signed [hfsl_pkg::VEL_W-1:0] velocity_north_i,
  input  logic signed [hfsl_pkg::VEL_W-1:0] velocity_east_i,
  input  hfsl_pkg::cfg_t                  cfg_i,
  output logic                            q_push_o,
  input  logic                            q_full_i,
  output hfsl_pkg::item_t                 q_item_o
);

  logic                              valid_q, valid_d;
  logic                              seed_q, vel_ok_q;
  logic [hfsl_pkg::HEAD_W-1:0]       heading_q;
  logic signed [hfsl_pkg::VEL_W-1:0] north_q, east_q;
  logic [hfsl_pkg::SQ_W-1:0]         north_sq_q, east_sq_q;
  logic signed [2*hfsl_pkg::VEL_W-1:0] north_prod, east_prod;
  logic [hfsl_pkg::SQ_W:0]           speed_sq;
  logic                              accept;

  assign full   = valid_q && q_full_i;
  assign accept = push && !full;

  assign north_prod = velocity_north_i * velocity_north_i;
  assign east_prod  = velocity_east_i * velocity_east_i;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (q_push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      seed_q     <= seed_i;
      vel_ok_q   <= velocity_valid_i;
      heading_q  <= seed_heading_i;
      north_q    <= velocity_north_i;
      east_q     <= velocity_east_i;
      north_sq_q <= north_prod[hfsl_pkg::SQ_W-1:0];
      east_sq_q  <= east_prod[hfsl_pkg::SQ_W-1:0];
    end
  end

  // classify: seed, follow (fast enough), or hold
  assign speed_sq = {1'b0, north_sq_q} + {1'b0, east_sq_q};
  assign q_push_o = valid_q && !q_full_i;

  always_comb begin
    q_item_o.heading = heading_q;
    q_item_o.north   = north_q;
    q_item_o.east    = east_q;
    if (seed_q) begin
      q_item_o.kind = hfsl_pkg::KIND_SEED;
    end else if (vel_ok_q && (speed_sq > (hfsl_pkg::SQ_W+1)'(cfg_i.speed_sq))) begin
      q_item_o.kind = hfsl_pkg::KIND_FOLLOW;
    end else begin
      q_item_o.kind = hfsl_pkg::KIND_HOLD;
    end
  end

endmodule

/* sv/hfsl_fifo.sv */
module hfsl_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = hfsl_pkg::DEF_QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* sv/hfsl_back.sv */
module hfsl_back #(
  parameter int ANGLE_BITS   = hfsl_pkg::DEF_ANGLE_BITS,
  parameter int CORDIC_STEPS = hfsl_pkg::DEF_CORDIC_STEPS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  hfsl_pkg::cfg_t              cfg_i,
  input  logic                        q_empty_i,
  output logic                        q_pop_o,
  input  hfsl_pkg::item_t             q_item_i,
  output logic                        empty,
  input  logic                        pop,
  output logic signed [hfsl_pkg::HEAD_W-1:0] commanded_heading_o,
  output logic                        following_o
);

  `include "assert_macros.svh"

  localparam int XY_W  = hfsl_pkg::XY_W;
  localparam int HW    = hfsl_pkg::HEAD_W;
  localparam int CNT_W = $clog2(CORDIC_STEPS);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(CORDIC_STEPS - 1);
  localparam int UP     = (ANGLE_BITS > HW) ? ANGLE_BITS - HW : 0;
  localparam int DOWN   = (ANGLE_BITS < HW) ? HW - ANGLE_BITS : 0;
  localparam int EXT_W  = ANGLE_BITS + DOWN;
  localparam int RND_SH = (UP > 0) ? UP - 1 : 0;
  localparam logic [EXT_W:0] HALF = (UP > 0) ? ((EXT_W+1)'(1) << RND_SH) : '0;
  localparam logic [32:0] A_RND = 33'(1) << (31 - ANGLE_BITS);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_ROUND = 4'b0100,
    ST_APPLY = 4'b1000
  } state_e;

  state_e                   state_q, state_d;
  hfsl_pkg::kind_e          kind_q;
  logic [CNT_W-1:0]         cnt_q;
  logic signed [XY_W-1:0]   x_q, y_q, dx, dy, x_init, y_init;
  logic [ANGLE_BITS-1:0]    z_q, angle;
  logic [32:0]              angle_sum;
  logic [HW-1:0]            desired_q, held_q, diff, step, next_heading;
  logic [EXT_W-1:0]         z_ext;
  logic [EXT_W:0]           z_rnd;
  logic signed [HW:0]       diff_s, lim_s, clamped;
  logic                     out_valid_q, out_valid_d, apply_fire;

  assign q_pop_o    = (state_q == ST_IDLE) && !q_empty_i;
  assign apply_fire = (state_q == ST_APPLY) && (!out_valid_q || pop);

  // prescale by 2^14; the left half plane is folded into the right one when the item is loaded
  always_comb begin
    x_init = XY_W'(q_item_i.north) <<< hfsl_pkg::PRESCALE;
    y_init = XY_W'(q_item_i.east) <<< hfsl_pkg::PRESCALE;
  end

  assign dx        = y_q >>> cnt_q;
  assign dy        = x_q >>> cnt_q;
  assign angle_sum = {1'b0, hfsl_pkg::atan_turn(5'(cnt_q))} + A_RND;
  assign angle     = angle_sum[32-ANGLE_BITS +: ANGLE_BITS];

  // round the accumulator to a 16-bit angle, ties upward
  assign z_ext = EXT_W'(z_q) << DOWN;
  assign z_rnd = {1'b0, z_ext} + HALF;

  // wrapped difference, clamped to the per-tick step; a seed item takes its heading directly
  always_comb begin
    diff   = desired_q - held_q;
    diff_s = {diff[HW-1], diff};
    lim_s  = (HW+1)'(cfg_i.step_limit);
    clamped = diff_s;
    if (diff_s > lim_s) begin
      clamped = lim_s;
    end else if (diff_s < -lim_s) begin
      clamped = -lim_s;
    end
    step = clamped[HW-1:0];
    if (kind_q == hfsl_pkg::KIND_SEED) begin
      next_heading = desired_q;
    end else begin
      next_heading = held_q + step;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          state_d = (q_item_i.kind == hfsl_pkg::KIND_FOLLOW) ? ST_RUN : ST_APPLY;
        end
      end
      ST_RUN: begin
        if (cnt_q == LAST) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: state_d = ST_APPLY;
      ST_APPLY: begin
        if (apply_fire) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = (out_valid_q && !pop) || apply_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      held_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (apply_fire) begin
        held_q <= next_heading;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        kind_q <= q_item_i.kind;
        cnt_q  <= '0;
        if (q_item_i.kind == hfsl_pkg::KIND_SEED) begin
          desired_q <= q_item_i.heading;
        end else begin
          desired_q <= held_q;
        end
        if (x_init[XY_W-1]) begin
          x_q <= -x_init;
          y_q <= -y_init;
          z_q <= ANGLE_BITS'(1) << (ANGLE_BITS - 1);
        end else begin
          x_q <= x_init;
          y_q <= y_init;
          z_q <= '0;
        end
      end
      ST_RUN: begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (!y_q[XY_W-1] && (y_q != '0)) begin
          x_q <= x_q + dx;
          y_q <= y_q - dy;
          z_q <= z_q + angle;
        end else begin
          x_q <= x_q - dx;
          y_q <= y_q + dy;
          z_q <= z_q - angle;
        end
      end
      ST_ROUND: desired_q <= z_rnd[UP +: HW];
      default: ;
    endcase
    if (apply_fire) begin
      commanded_heading_o <= next_heading;
      following_o         <= (kind_q == hfsl_pkg::KIND_FOLLOW);
    end
  end

  assign empty = !out_valid_q;

  `HFSL_ASSERT_IMP(a_x_nonneg, state_q == ST_RUN, !x_q[XY_W-1], "CORDIC x went negative")
  `HFSL_ASSERT_NXT(a_run_end, (state_q == ST_RUN) && (cnt_q == LAST), state_q == ST_ROUND,
                   "CORDIC did not stop after last step")
  `HFSL_ASSERT_IMP(a_out_src, $rose(out_valid_q), $past(state_q == ST_APPLY),
                   "result appeared outside apply")

endmodule
